// ----- sv/task_slot_round_robin_scheduler_core_macros.svh -----
// Assertion macros used by the scheduler port checker.
`ifndef TASK_SLOT_ROUND_ROBIN_SCHEDULER_CORE_MACROS_SVH
`define TASK_SLOT_ROUND_ROBIN_SCHEDULER_CORE_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define TSRR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked while reset is high.
`define TSRR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define TSRR_ASSERT_NEXT_RST(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/tsrr_pkg.sv -----
// Shared constants and state type of the task slot scheduler.
package tsrr_pkg;

   localparam int SLOTS       = 16;
   localparam int SLOT_W      = 4;
   localparam int WAIT_QUEUES = 4;
   localparam int WQ_W        = 2;
   localparam int LEN_W       = 5;
   localparam int STACK_BYTES = 512;

   localparam logic [31:0] NO_STACK_TOP = 32'h0000_6210;

   // request codes
   localparam logic [2:0] REQ_SPAWN    = 3'd0;
   localparam logic [2:0] REQ_EXIT     = 3'd1;
   localparam logic [2:0] REQ_SLEEP    = 3'd2;
   localparam logic [2:0] REQ_WAKE     = 3'd3;
   localparam logic [2:0] REQ_BLOCK    = 3'd4;
   localparam logic [2:0] REQ_FREE     = 3'd5;
   localparam logic [2:0] REQ_SCHEDULE = 3'd6;

   // result status codes
   localparam logic [1:0] STS_OK       = 2'd0;
   localparam logic [1:0] STS_NO_SLOT  = 2'd1;
   localparam logic [1:0] STS_NO_STACK = 2'd2;
   localparam logic [1:0] STS_Q_EMPTY  = 2'd3;

   // slot states
   localparam logic [1:0] SS_FREE  = 2'd0;
   localparam logic [1:0] SS_RUN   = 2'd1;
   localparam logic [1:0] SS_SLEEP = 2'd2;

   typedef struct packed {
      logic [SLOTS-1:0][1:0]                 sstat;
      logic [SLOTS-1:0]                      stk_use;
      logic [SLOTS-1:0]                      stk_vld;
      logic [SLOTS-1:0][SLOT_W-1:0]          stk_idx;
      logic [SLOTS-1:0][SLOT_W-1:0]          rnext;
      logic [SLOTS-1:0][SLOT_W-1:0]          rprev;
      logic [SLOTS-1:0]                      inrun;
      logic [SLOT_W-1:0]                     rhead;
      logic [SLOT_W-1:0]                     rtail;
      logic [LEN_W-1:0]                      rlen;
      logic [SLOTS-1:0][SLOT_W-1:0]          wnext;
      logic [SLOTS-1:0]                      wmem;
      logic [SLOTS-1:0][WQ_W-1:0]            wq;
      logic [WAIT_QUEUES-1:0][SLOT_W-1:0]    whead;
      logic [WAIT_QUEUES-1:0][SLOT_W-1:0]    wtail;
      logic [WAIT_QUEUES-1:0][LEN_W-1:0]     wlen;
      logic [SLOT_W-1:0]                     cur;
   } sched_state_type;

endpackage

// ----- sv/task_slot_round_robin_scheduler_core.sv -----
// Task slot round-robin scheduler: slot table, run FIFO and wait queues.
// The block takes one request word per cycle into an input register, applies it
// to the slot table, run FIFO and wait queues in a single combinational pass,
// and presents one response word from a result register once the response side
// is free. A new request is accepted every cycle while the response side keeps
// up; a stalled response holds the request in the input register.
// csr_wr_data sets the stack region base; write it only while no request is
// in flight. Spawned slots get stack i at base + i*(STACK_BYTES+1).
module task_slot_round_robin_scheduler_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic [3:0]  req_target_slot,
   input  logic [1:0]  req_queue_id,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_affected_slot,
   output logic [3:0]  rsp_running_slot,
   output logic        rsp_switched,
   output logic [31:0] rsp_stack_top,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   localparam int SW = tsrr_pkg::SLOT_W;
   localparam int LW = tsrr_pkg::LEN_W;
   localparam int QW = tsrr_pkg::WQ_W;

   tsrr_pkg::sched_state_type st_ff, st_in;

   logic [31:0]   base_ff;
   logic          in_vld_ff;
   logic [2:0]    in_type_ff;
   logic [SW-1:0] in_tgt_ff;
   logic [QW-1:0] in_q_ff;

   logic          out_vld_ff;
   logic [1:0]    out_status_ff, out_status_in;
   logic [SW-1:0] out_aff_ff, out_aff_in;
   logic [SW-1:0] out_run_ff;
   logic          out_sw_ff, out_sw_in;
   logic [31:0]   out_top_ff, out_top_in;

   logic proc;

   // slot 0 running with stack 0, everything else empty
   function automatic tsrr_pkg::sched_state_type reset_state();
      tsrr_pkg::sched_state_type r;
      r = '0;
      r.sstat[0] = tsrr_pkg::SS_RUN;
      r.stk_use[0] = 1'b1;
      r.stk_vld[0] = 1'b1;
      return r;
   endfunction

   function automatic tsrr_pkg::sched_state_type run_push(
      tsrr_pkg::sched_state_type st, logic [SW-1:0] s);
      tsrr_pkg::sched_state_type r;
      r = st;
      if (!r.inrun[s]) begin
         if (r.rlen == '0) begin
            r.rhead = s;
         end else begin
            r.rnext[r.rtail] = s;
            r.rprev[s] = r.rtail;
         end
         r.rtail = s;
         r.rlen = r.rlen + LW'(1);
         r.inrun[s] = 1'b1;
      end
      return r;
   endfunction

   function automatic tsrr_pkg::sched_state_type run_remove(
      tsrr_pkg::sched_state_type st, logic [SW-1:0] s);
      tsrr_pkg::sched_state_type r;
      logic [SW-1:0] p;
      logic [SW-1:0] n;
      r = st;
      if (r.inrun[s]) begin
         p = r.rprev[s];
         n = r.rnext[s];
         if (r.rhead == s) r.rhead = n;
         else r.rnext[p] = n;
         if (r.rtail == s) r.rtail = p;
         else r.rprev[n] = p;
         r.rlen = r.rlen - LW'(1);
         r.inrun[s] = 1'b0;
      end
      return r;
   endfunction

   function automatic tsrr_pkg::sched_state_type wait_push(
      tsrr_pkg::sched_state_type st, logic [QW-1:0] q, logic [SW-1:0] s);
      tsrr_pkg::sched_state_type r;
      r = st;
      if (!r.wmem[s]) begin
         if (r.wlen[q] == '0) r.whead[q] = s;
         else r.wnext[r.wtail[q]] = s;
         r.wtail[q] = s;
         r.wlen[q] = r.wlen[q] + LW'(1);
         r.wmem[s] = 1'b1;
         r.wq[s] = q;
      end
      return r;
   endfunction

   function automatic tsrr_pkg::sched_state_type wait_pop(
      tsrr_pkg::sched_state_type st, logic [QW-1:0] q);
      tsrr_pkg::sched_state_type r;
      logic [SW-1:0] s;
      r = st;
      s = r.whead[q];
      r.whead[q] = r.wnext[s];
      r.wlen[q] = r.wlen[q] - LW'(1);
      r.wmem[s] = 1'b0;
      return r;
   endfunction

   // predecessor found by matching links of the same queue in parallel
   function automatic tsrr_pkg::sched_state_type wait_unlink(
      tsrr_pkg::sched_state_type st, logic [SW-1:0] s);
      tsrr_pkg::sched_state_type r;
      logic [QW-1:0] q;
      logic          hit;
      logic [SW-1:0] p;
      r = st;
      hit = 1'b0;
      p = '0;
      if (r.wmem[s]) begin
         q = r.wq[s];
         if (r.whead[q] == s) begin
            r = wait_pop(r, q);
         end else begin
            for (int i = 0; i < tsrr_pkg::SLOTS; i++) begin
               if (r.wmem[i] && r.wq[i] == q && SW'(i) != r.wtail[q] &&
                   r.wnext[i] == s) begin
                  hit = 1'b1;
                  p = SW'(i);
               end
            end
            if (hit) begin
               r.wnext[p] = r.wnext[s];
               if (r.wtail[q] == s) r.wtail[q] = p;
               r.wlen[q] = r.wlen[q] - LW'(1);
            end
            r.wmem[s] = 1'b0;
         end
      end
      return r;
   endfunction

   function automatic tsrr_pkg::sched_state_type release_slot(
      tsrr_pkg::sched_state_type st, logic [SW-1:0] s);
      tsrr_pkg::sched_state_type r;
      r = st;
      if (r.stk_vld[s]) r.stk_use[r.stk_idx[s]] = 1'b0;
      r.stk_vld[s] = 1'b0;
      r = run_remove(r, s);
      r = wait_unlink(r, s);
      r.sstat[s] = tsrr_pkg::SS_FREE;
      return r;
   endfunction

   function automatic tsrr_pkg::sched_state_type schedule_step(
      tsrr_pkg::sched_state_type st);
      tsrr_pkg::sched_state_type r;
      logic [SW-1:0] nxt;
      r = st;
      nxt = r.rhead;
      if (r.rlen != '0 && nxt != r.cur) begin
         if (r.sstat[r.cur] == tsrr_pkg::SS_RUN) r = run_push(r, r.cur);
         r = run_remove(r, nxt);
         r.cur = nxt;
      end
      return r;
   endfunction

   assign proc      = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || proc;

   always_comb begin
      logic          slot_hit;
      logic [SW-1:0] slot_sel;
      logic          stk_hit;
      logic [SW-1:0] stk_sel;
      logic [SW-1:0] woke;
      st_in         = st_ff;
      out_status_in = tsrr_pkg::STS_OK;
      out_aff_in    = '0;
      out_top_in    = '0;
      slot_hit      = 1'b0;
      slot_sel      = '0;
      stk_hit       = 1'b0;
      stk_sel       = '0;
      woke          = st_ff.whead[in_q_ff];
      for (int i = tsrr_pkg::SLOTS - 1; i >= 0; i--) begin
         if (st_ff.sstat[i] == tsrr_pkg::SS_FREE) begin
            slot_hit = 1'b1;
            slot_sel = SW'(i);
         end
         if (!st_ff.stk_use[i]) begin
            stk_hit = 1'b1;
            stk_sel = SW'(i);
         end
      end
      case (in_type_ff)
         tsrr_pkg::REQ_SPAWN: begin
            if (!slot_hit) begin
               out_status_in = tsrr_pkg::STS_NO_SLOT;
            end else begin
               out_aff_in = slot_sel;
               if (stk_hit) begin
                  st_in.stk_use[stk_sel] = 1'b1;
                  st_in.stk_vld[slot_sel] = 1'b1;
                  st_in.stk_idx[slot_sel] = stk_sel;
                  out_top_in = base_ff +
                     32'(stk_sel) * 32'(tsrr_pkg::STACK_BYTES + 1);
               end else begin
                  st_in.stk_vld[slot_sel] = 1'b0;
                  out_status_in = tsrr_pkg::STS_NO_STACK;
                  out_top_in = tsrr_pkg::NO_STACK_TOP;
               end
               st_in.sstat[slot_sel] = tsrr_pkg::SS_RUN;
               st_in = run_push(st_in, slot_sel);
            end
         end
         tsrr_pkg::REQ_EXIT: begin
            out_aff_in = st_ff.cur;
            st_in = release_slot(st_in, st_ff.cur);
            st_in = schedule_step(st_in);
         end
         tsrr_pkg::REQ_SLEEP: begin
            out_aff_in = st_ff.cur;
            if (st_ff.sstat[st_ff.cur] == tsrr_pkg::SS_RUN && !st_ff.wmem[st_ff.cur]) begin
               st_in = run_remove(st_in, st_ff.cur);
               st_in.sstat[st_ff.cur] = tsrr_pkg::SS_SLEEP;
               st_in = wait_push(st_in, in_q_ff, st_ff.cur);
            end
            st_in = schedule_step(st_in);
         end
         tsrr_pkg::REQ_WAKE: begin
            if (st_ff.wlen[in_q_ff] == '0) begin
               out_status_in = tsrr_pkg::STS_Q_EMPTY;
            end else begin
               st_in = wait_pop(st_in, in_q_ff);
               st_in.sstat[woke] = tsrr_pkg::SS_RUN;
               st_in = run_push(st_in, woke);
               out_aff_in = woke;
            end
         end
         tsrr_pkg::REQ_BLOCK: begin
            st_in = run_remove(st_in, in_tgt_ff);
            st_in.sstat[in_tgt_ff] = tsrr_pkg::SS_SLEEP;
            out_aff_in = in_tgt_ff;
         end
         tsrr_pkg::REQ_FREE: begin
            st_in = release_slot(st_in, in_tgt_ff);
            out_aff_in = in_tgt_ff;
         end
         tsrr_pkg::REQ_SCHEDULE: begin
            st_in = schedule_step(st_in);
         end
         default: begin
         end
      endcase
      out_sw_in = (st_in.cur != st_ff.cur);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= reset_state();
         base_ff       <= '0;
         in_vld_ff     <= 1'b0;
         out_vld_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) base_ff <= csr_wr_data;
         if (req_ready) in_vld_ff <= req_valid;
         if (proc) begin
            st_ff      <= st_in;
            out_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_type_ff <= req_type;
         in_tgt_ff  <= req_target_slot;
         in_q_ff    <= req_queue_id;
      end
      if (proc) begin
         out_status_ff <= out_status_in;
         out_aff_ff    <= out_aff_in;
         out_run_ff    <= st_in.cur;
         out_sw_ff     <= out_sw_in;
         out_top_ff    <= out_top_in;
      end
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_affected_slot = out_aff_ff;
   assign rsp_running_slot  = out_run_ff;
   assign rsp_switched      = out_sw_ff;
   assign rsp_stack_top     = out_top_ff;

endmodule

// ----- sv/tsrr_checker.sv -----
// Port-level checks for the scheduler, bound to the top level.
`include "task_slot_round_robin_scheduler_core_macros.svh"

module tsrr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [3:0]  rsp_running_slot,
   input logic        rsp_switched,
   input logic [31:0] rsp_stack_top
);

   // a held response word keeps its running slot
   `TSRR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_running_slot), "response dropped or changed while stalled")

   `TSRR_ASSERT_NEXT_RST(a_rst_empty, clock, reset, !rsp_valid, "response valid right after reset")

   `TSRR_ASSERT_NOW(a_no_stack_top, clock, reset, rsp_valid && rsp_status == tsrr_pkg::STS_NO_STACK, rsp_stack_top == tsrr_pkg::NO_STACK_TOP, "missing-stack marker wrong")

   // a failed spawn touches nothing
   `TSRR_ASSERT_NOW(a_no_slot, clock, reset, rsp_valid && rsp_status == tsrr_pkg::STS_NO_SLOT, !rsp_switched && rsp_stack_top == 32'd0, "failed spawn changed state")

endmodule

bind task_slot_round_robin_scheduler_core tsrr_checker u_tsrr_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_status       (rsp_status),
   .rsp_running_slot (rsp_running_slot),
   .rsp_switched     (rsp_switched),
   .rsp_stack_top    (rsp_stack_top)
);

// ----- verif/task_slot_round_robin_scheduler_core_checker.sv -----
// Scheduler checker: tracks the slot table, predicts each response word and compares.
`timescale 1ns / 1ps
module task_slot_round_robin_scheduler_core_checker
   import tsrr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic [3:0]  req_target_slot,
   input  logic [1:0]  req_queue_id,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_status,
   input  logic [3:0]  rsp_affected_slot,
   input  logic [3:0]  rsp_running_slot,
   input  logic        rsp_switched,
   input  logic [31:0] rsp_stack_top,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   output int          fail_count,
   output int          words_pending
);

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  affected;
      logic [3:0]  running;
      logic        switched;
      logic [31:0] stack_top;
   } sched_rsp_type;

   sched_rsp_type expected_rsp_q[$];

   logic [31:0] stack_base;
   logic [1:0]  slot_state [SLOTS];
   logic        stack_busy [SLOTS];
   int          slot_stack [SLOTS];   // -1: no stack held
   logic [3:0]  rq_next [SLOTS];
   logic [3:0]  rq_prev [SLOTS];
   logic        rq_member [SLOTS];
   logic [3:0]  rq_head, rq_tail;
   int          rq_len;
   logic [3:0]  wq_next [SLOTS];
   int          wq_owner [SLOTS];     // 0: none, else queue + 1
   logic [3:0]  wq_head [WAIT_QUEUES];
   logic [3:0]  wq_tail [WAIT_QUEUES];
   int          wq_len [WAIT_QUEUES];
   logic [3:0]  cur_slot;

   assign words_pending = expected_rsp_q.size();

   function automatic void clear_table();
      for (int i = 0; i < SLOTS; i++) begin
         slot_state[i] = SS_FREE;
         stack_busy[i] = 1'b0;
         slot_stack[i] = -1;
         rq_next[i] = '0;
         rq_prev[i] = '0;
         rq_member[i] = 1'b0;
         wq_next[i] = '0;
         wq_owner[i] = 0;
      end
      for (int q = 0; q < WAIT_QUEUES; q++) begin
         wq_head[q] = '0;
         wq_tail[q] = '0;
         wq_len[q] = 0;
      end
      rq_head = '0;
      rq_tail = '0;
      rq_len = 0;
      cur_slot = '0;
      stack_base = '0;
      slot_state[0] = SS_RUN;
      stack_busy[0] = 1'b1;
      slot_stack[0] = 0;
   endfunction

   function automatic void run_append(logic [3:0] s);
      if (rq_member[s]) return;
      if (rq_len == 0) rq_head = s;
      else begin
         rq_next[rq_tail] = s;
         rq_prev[s] = rq_tail;
      end
      rq_tail = s;
      rq_len++;
      rq_member[s] = 1'b1;
   endfunction

   function automatic void run_unlink(logic [3:0] s);
      logic [3:0] p, n;
      if (!rq_member[s]) return;
      p = rq_prev[s];
      n = rq_next[s];
      if (rq_head == s) rq_head = n; else rq_next[p] = n;
      if (rq_tail == s) rq_tail = p; else rq_prev[n] = p;
      rq_len--;
      rq_member[s] = 1'b0;
   endfunction

   function automatic void wait_append(int q, logic [3:0] s);
      if (wq_owner[s] != 0) return;
      if (wq_len[q] == 0) wq_head[q] = s; else wq_next[wq_tail[q]] = s;
      wq_tail[q] = s;
      wq_len[q]++;
      wq_owner[s] = q + 1;
   endfunction

   function automatic logic [3:0] wait_take(int q);
      logic [3:0] s;
      s = wq_head[q];
      wq_head[q] = wq_next[s];
      wq_len[q]--;
      wq_owner[s] = 0;
      return s;
   endfunction

   function automatic void wait_drop(logic [3:0] s);
      int q;
      logic [3:0] p, dummy;
      if (wq_owner[s] == 0) return;
      q = wq_owner[s] - 1;
      if (wq_head[q] == s) begin
         dummy = wait_take(q);
         return;
      end
      p = wq_head[q];
      for (int i = 0; i < wq_len[q]; i++) begin
         if (wq_next[p] == s) begin
            wq_next[p] = wq_next[s];
            if (wq_tail[q] == s) wq_tail[q] = p;
            wq_len[q]--;
            wq_owner[s] = 0;
            return;
         end
         p = wq_next[p];
      end
      wq_owner[s] = 0;
   endfunction

   function automatic void retire_slot(logic [3:0] s);
      if (slot_stack[s] >= 0) stack_busy[slot_stack[s]] = 1'b0;
      slot_stack[s] = -1;
      run_unlink(s);
      wait_drop(s);
      slot_state[s] = SS_FREE;
   endfunction

   function automatic void pick_next();
      logic [3:0] nxt;
      if (rq_len == 0) return;
      nxt = rq_head;
      if (nxt == cur_slot) return;
      if (slot_state[cur_slot] == SS_RUN) run_append(cur_slot);
      run_unlink(nxt);
      cur_slot = nxt;
   endfunction

   function automatic sched_rsp_type apply_request(logic [2:0] t, logic [3:0] tgt,
                                                   logic [1:0] qid);
      sched_rsp_type r;
      logic [3:0] old;
      int s;
      old = cur_slot;
      r = '0;
      case (t)
         REQ_SPAWN: begin
            s = 0;
            while (s < SLOTS && slot_state[s] != SS_FREE) s++;
            if (s >= SLOTS) r.status = STS_NO_SLOT;
            else begin
               r.affected = s;
               r.stack_top = NO_STACK_TOP;
               r.status = STS_NO_STACK;
               slot_stack[s] = -1;
               for (int i = 0; i < SLOTS; i++) begin
                  if (!stack_busy[i]) begin
                     stack_busy[i] = 1'b1;
                     slot_stack[s] = i;
                     r.stack_top = stack_base + i * (STACK_BYTES + 1);
                     r.status = STS_OK;
                     break;
                  end
               end
               slot_state[s] = SS_RUN;
               run_append(s);
            end
         end
         REQ_EXIT: begin
            r.affected = old;
            retire_slot(old);
            pick_next();
         end
         REQ_SLEEP: begin
            r.affected = old;
            if (slot_state[old] == SS_RUN && wq_owner[old] == 0) begin
               run_unlink(old);
               slot_state[old] = SS_SLEEP;
               wait_append(qid, old);
            end
            pick_next();
         end
         REQ_WAKE: begin
            if (wq_len[qid] == 0) r.status = STS_Q_EMPTY;
            else begin
               r.affected = wait_take(qid);
               slot_state[r.affected] = SS_RUN;
               run_append(r.affected);
            end
         end
         REQ_BLOCK: begin
            run_unlink(tgt);
            slot_state[tgt] = SS_SLEEP;
            r.affected = tgt;
         end
         REQ_FREE: begin
            retire_slot(tgt);
            r.affected = tgt;
         end
         REQ_SCHEDULE: pick_next();
         default: ;
      endcase
      r.running = cur_slot;
      r.switched = (cur_slot != old);
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      clear_table();
   end

   always @(posedge clock) begin
      sched_rsp_type e;
      if (reset) begin
         clear_table();
         expected_rsp_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0)
               report_mismatch("unexpected response word", 1, 0);
            else begin
               e = expected_rsp_q.pop_front();
               if (rsp_status !== e.status) report_mismatch("status", rsp_status, e.status);
               if (rsp_affected_slot !== e.affected)
                  report_mismatch("affected_slot", rsp_affected_slot, e.affected);
               if (rsp_running_slot !== e.running)
                  report_mismatch("running_slot", rsp_running_slot, e.running);
               if (rsp_switched !== e.switched)
                  report_mismatch("switched", rsp_switched, e.switched);
               if (rsp_stack_top !== e.stack_top)
                  report_mismatch("stack_top", rsp_stack_top, e.stack_top);
            end
         end
         if (req_valid && req_ready)
            expected_rsp_q.push_back(apply_request(req_type, req_target_slot, req_queue_id));
         if (csr_wr_en) stack_base = csr_wr_data;
      end
   end

endmodule

// ----- verif/task_slot_round_robin_scheduler_core_tb.sv -----
// Testbench top for the task slot scheduler: stimulus, pacing and verdict.
`timescale 1ns / 1ps
module task_slot_round_robin_scheduler_core_tb;
   import tsrr_pkg::*;

   localparam int CYCLE_LIMIT = 300000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_type;
   logic [3:0]  req_target_slot;
   logic [1:0]  req_queue_id;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_affected_slot;
   logic [3:0]  rsp_running_slot;
   logic        rsp_switched;
   logic [31:0] rsp_stack_top;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;

   int fail_count;
   int words_pending;
   int cycle_count;
   bit quiet;          // no idling on either side
   bit sender_idles;
   bit hold_request;   // ask the receiver for a long stall

   task_slot_round_robin_scheduler_core u_top (.*);

   task_slot_round_robin_scheduler_core_checker u_checker (.*);

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // receiver side
   initial begin
      int stall_left;
      int long_left;
      stall_left = 0;
      long_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            long_left = 120;
         end
         if (long_left > 0) begin
            rsp_ready = 1'b0;
            long_left--;
         end else if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_ready = 1'b0;
            stall_left = $urandom_range(1, 9) - 1;
         end else
            rsp_ready = 1'b1;
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic issue_request(logic [2:0] t, logic [3:0] tgt, logic [1:0] qid);
      bit taken;
      if (!quiet && sender_idles && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 9)) @(negedge clock);
      req_valid = 1'b1;
      req_type = t;
      req_target_slot = tgt;
      req_queue_id = qid;
      forever begin
         #1;
         taken = req_ready;
         @(negedge clock);
         if (taken) break;
      end
      req_valid = 1'b0;
   endtask

   task automatic drain_and_write_base(logic [31:0] base);
      while (words_pending != 0) @(negedge clock);
      repeat (6) @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = base;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic random_request();
      int pick;
      logic [2:0] t;
      pick = $urandom_range(0, 99);
      if (pick < 25) t = REQ_SPAWN;
      else if (pick < 33) t = REQ_EXIT;
      else if (pick < 48) t = REQ_SLEEP;
      else if (pick < 63) t = REQ_WAKE;
      else if (pick < 71) t = REQ_BLOCK;
      else if (pick < 79) t = REQ_FREE;
      else if (pick < 97) t = REQ_SCHEDULE;
      else t = 3'd7;
      issue_request(t, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
   endtask

   initial begin
      logic [31:0] bases [4];
      cycle_count = 0;
      quiet = 1'b0;
      sender_idles = 1'b1;
      hold_request = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = REQ_SPAWN;
      req_target_slot = '0;
      req_queue_id = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty-run schedule, fill all slots, overflow, each queue, block, free, exit, unused code
      issue_request(REQ_SCHEDULE, 4'd0, 2'd0);
      drain_and_write_base(32'h0000_1000);
      for (int i = 0; i < 16; i++) issue_request(REQ_SPAWN, 4'd0, 2'd0);
      issue_request(REQ_SCHEDULE, 4'd0, 2'd0);
      for (int q = 0; q < 4; q++) issue_request(REQ_SLEEP, 4'd0, 2'(q));
      issue_request(REQ_SLEEP, 4'd0, 2'd3);
      for (int q = 0; q < 4; q++) issue_request(REQ_WAKE, 4'd0, 2'(q));
      issue_request(REQ_WAKE, 4'd0, 2'd1);
      issue_request(REQ_BLOCK, 4'd15, 2'd0);
      issue_request(REQ_FREE, 4'd15, 2'd0);
      issue_request(REQ_EXIT, 4'd0, 2'd0);
      issue_request(3'd7, 4'd15, 2'd3);
      issue_request(REQ_SPAWN, 4'd0, 2'd0);

      bases[0] = 32'hffff_ffff;
      bases[1] = $urandom;
      bases[2] = 32'h0000_0000;
      bases[3] = 32'hffff_fe00;
      for (int ph = 0; ph < 4; ph++) begin
         drain_and_write_base(bases[ph]);
         quiet = (ph == 3);
         for (int n = 0; n < 200; n++) begin
            if (n % 40 == 0) sender_idles = ($urandom_range(0, 2) != 0);
            if (ph == 1 && n == 50) hold_request = 1'b1;
            if (ph == 2 && n == 100) begin
               // sender pauses until every response is back
               while (words_pending != 0) @(negedge clock);
            end
            random_request();
         end
      end

      while (words_pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+sv
sv/tsrr_pkg.sv
sv/task_slot_round_robin_scheduler_core.sv
sv/tsrr_checker.sv
verif/task_slot_round_robin_scheduler_core_checker.sv
verif/task_slot_round_robin_scheduler_core_tb.sv
